>>> src/conv3_pkg.sv
// ---------------------------------------------------------------------------
// conv3_pkg: shared types and constants for the 3x3 zero-padded filter
// Pixel/result formats, register indexes, kernel tables, mean scaling.
// ---------------------------------------------------------------------------
`default_nettype none

package conv3_pkg;

  // Field widths
  localparam int PIXEL_BITS    = 10;
  localparam int FRACTION_BITS = 4;
  localparam int OUT_BITS      = 18;
  localparam int POS_BITS      = 10;
  localparam int CFG_BITS      = 11;
  localparam int MODE_BITS     = 2;
  localparam int INDEX_BITS    = 2;

  // Weighted sum: |S| <= 17 * 512 for the sharpen kernel
  localparam int SUM_BITS   = 15;
  localparam int SWIDE_BITS = SUM_BITS + FRACTION_BITS;

  // Geometry defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RESET_WIDTH    = 256;
  localparam int RESET_HEIGHT   = 256;

  // Register indexes
  localparam logic [INDEX_BITS-1:0] REG_KERNEL_MODE  = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Kernel mode codes (the unused code acts as the mean)
  localparam logic [MODE_BITS-1:0] MODE_MEAN    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SHARPEN = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LAPLACE = 2'd2;

  // Mean: round(16*S/9) = floor(p/9) - Q_OFFSET, p = 16*S + 9*Q_OFFSET + 4 >= 0.
  // floor(p/9) = (p * RECIP) >> RECIP_SHIFT, exact for p < 2^18.
  localparam int MEAN_Q_OFFSET = 2 ** (PIXEL_BITS + FRACTION_BITS - 1);
  localparam int MEAN_P_OFFSET = 9 * MEAN_Q_OFFSET + 4;
  localparam int MEAN_P_BITS   = 18;
  localparam int RECIP_SHIFT   = 21;
  localparam int RECIP         = (2 ** RECIP_SHIFT + 8) / 9;
  localparam int PROD_BITS     = 2 * MEAN_P_BITS;
  localparam int QUO_BITS      = PROD_BITS - RECIP_SHIFT;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [OUT_BITS-1:0]   result_t;
  typedef logic [POS_BITS-1:0]          pos_t;
  typedef logic signed [4:0]            coef_t;

  // Correlation kernels: [row][column], row 0 is the row above
  localparam coef_t SHARPEN_K [3][3] = '{'{5'sd0, -5'sd3, 5'sd0},
                                         '{-5'sd1, 5'sd9, -5'sd3},
                                         '{5'sd0, -5'sd1, 5'sd0}};
  localparam coef_t LAPLACE_K [3][3] = '{'{5'sd0, -5'sd1, 5'sd0},
                                         '{-5'sd1, 5'sd4, -5'sd1},
                                         '{5'sd0, -5'sd1, 5'sd0}};

  // Per-item output control, decided when the item is taken
  typedef struct packed {
    logic emit;
    logic pad_top;
    logic pad_bottom;
    logic pad_left;
    logic pad_right;
    logic last;
    pos_t row;
    pos_t col;
  } emit_t;

  // One result word
  typedef struct packed {
    result_t value;
    pos_t    row;
    pos_t    col;
    logic    last;
  } out_word_t;

endpackage

`default_nettype wire

>>> src/conv3_ram.sv
// ---------------------------------------------------------------------------
// conv3_ram: generic simple dual-port RAM
// One write port, one read port, registered read (read-before-write).
// ---------------------------------------------------------------------------
`default_nettype none

module conv3_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/conv3_seq.sv
// ---------------------------------------------------------------------------
// conv3_seq: raster position sequencer
// Tracks the input position, issues the line buffer read and decides which
// output pixel (if any) the word produces, with its border padding.
// ---------------------------------------------------------------------------
`default_nettype none

module conv3_seq #(
  parameter int MAX_WIDTH  = conv3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = conv3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  conv3_pkg::pixel_t                 pixel_value,
  input  logic                              flush,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    img_width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   img_height,
  output logic                              rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  output logic                              s1_valid,
  output logic [$clog2(MAX_WIDTH)-1:0]      s1_addr,
  output conv3_pkg::pixel_t                 s1_pix,
  output conv3_pkg::emit_t                  s1_info
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 3);

  typedef logic [CW1-1:0] colx_t;
  typedef logic [RW-1:0]  row_t;

  logic [CW-1:0]     col_cnt;
  logic [CW-1:0]     col_next;
  row_t              row_cnt;
  row_t              row_next;
  colx_t             col0;
  colx_t             col_inc;
  row_t              row0;
  row_t              h_r;
  row_t              hp1;
  logic              take;
  logic              emit_a;
  logic              emit_b;
  logic              last;
  conv3_pkg::pixel_t pix;
  conv3_pkg::emit_t  info;

  assign take  = adv && in_valid;
  assign rd_en = take;
  assign h_r   = row_t'(img_height);
  assign hp1   = h_r + row_t'(1);

  // Position of this word after the geometry wrap checks
  always_comb begin
    col0 = colx_t'(col_cnt);
    row0 = row_cnt;
    if (col0 >= img_width) begin
      col0 = '0;
      row0 = row_cnt + row_t'(1);
    end
    if (row0 > hp1) begin
      col0 = '0;
      row0 = '0;
    end
  end

  assign rd_addr = col0[CW-1:0];

  // Pixels below the frame and flush words enter as zero
  assign pix = (flush || (row0 >= h_r)) ? '0 : pixel_value;

  // Output decision: at column 0 the last pixel of the row two back,
  // otherwise the pixel one row up and one column left.
  always_comb begin
    emit_a = (col0 == '0) && (row0 >= row_t'(2));
    emit_b = (col0 != '0) && (row0 != '0) && (row0 <= h_r);
    last   = emit_a && (row0 == hp1);
    info.emit = emit_a || emit_b;
    info.last = last;
    if (emit_a) begin
      info.pad_top    = (row0 == row_t'(2));
      info.pad_bottom = (row0 >= hp1);
      info.pad_left   = (img_width == colx_t'(1));
      info.pad_right  = 1'b1;
      info.row        = conv3_pkg::pos_t'(row0 - row_t'(2));
      info.col        = conv3_pkg::pos_t'(img_width - colx_t'(1));
    end else begin
      info.pad_top    = (row0 == row_t'(1));
      info.pad_bottom = (row0 >= h_r);
      info.pad_left   = (col0 == colx_t'(1));
      info.pad_right  = 1'b0;
      info.row        = conv3_pkg::pos_t'(row0 - row_t'(1));
      info.col        = conv3_pkg::pos_t'(col0 - colx_t'(1));
    end
  end

  // Next position
  always_comb begin
    col_inc = col0 + colx_t'(1);
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= img_width) begin
      col_next = '0;
      row_next = row0 + row_t'(1);
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = row0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (take) begin
        col_cnt <= col_next;
        row_cnt <= row_next;
      end
      if (adv) begin
        s1_valid <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr <= rd_addr;
      s1_pix  <= pix;
      s1_info <= info;
    end
  end

endmodule

`default_nettype wire

>>> src/conv3_line.sv
// ---------------------------------------------------------------------------
// conv3_line: line buffers, 3x3 window and weighted sum
// Both line buffers share one RAM word per column; each word is read,
// shifted up and written back, with forwarding for back-to-back access.
// ---------------------------------------------------------------------------
`default_nettype none

module conv3_line #(
  parameter int MAX_WIDTH = conv3_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic [conv3_pkg::MODE_BITS-1:0]      kernel_mode,
  input  logic                                 rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
  input  logic                                 s1_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]         s1_addr,
  input  conv3_pkg::pixel_t                    s1_pix,
  input  conv3_pkg::emit_t                     s1_info,
  output logic                                 s2_valid,
  output conv3_pkg::sum_t                      s2_sum,
  output logic                                 s2_mean,
  output conv3_pkg::emit_t                     s2_info
);

  localparam int PB = conv3_pkg::PIXEL_BITS;

  logic                 we;
  logic [2*PB-1:0]      ram_rd;
  logic [2*PB-1:0]      rd_word;
  logic [2*PB-1:0]      wr_data;
  logic                 fwd_hit;
  logic [2*PB-1:0]      fwd_data;
  conv3_pkg::pixel_t    newcol [3];
  conv3_pkg::pixel_t    wc1 [3];
  conv3_pkg::pixel_t    wc2 [3];
  conv3_pkg::pixel_t    view [3][3];
  logic                 row_keep [3];
  logic                 col_keep [3];
  conv3_pkg::sum_t      term;
  conv3_pkg::sum_t      sum_mean;
  conv3_pkg::sum_t      sum_sharp;
  conv3_pkg::sum_t      sum_lap;
  conv3_pkg::sum_t      sum_sel;
  logic                 mean_sel;

  // Word layout: {older row, newer row}
  conv3_ram #(
    .WIDTH (2 * PB),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (s1_addr),
    .wr_data (wr_data),
    .re      (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  assign we      = s1_valid && adv;
  assign rd_word = fwd_hit ? fwd_data : ram_rd;
  assign wr_data = {rd_word[PB-1:0], s1_pix};

  // Read issued in the same cycle as a write to that column sees old data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= we && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  // Incoming window column
  assign newcol[0] = rd_word[2*PB-1:PB];
  assign newcol[1] = rd_word[PB-1:0];
  assign newcol[2] = s1_pix;

  // Window: two stored columns, the third is the incoming one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        wc1[i] <= '0;
        wc2[i] <= '0;
      end
    end else if (we) begin
      for (int i = 0; i < 3; i++) begin
        wc1[i] <= wc2[i];
        wc2[i] <= newcol[i];
      end
    end
  end

  // Padding masks
  assign row_keep[0] = !s1_info.pad_top;
  assign row_keep[1] = 1'b1;
  assign row_keep[2] = !s1_info.pad_bottom;
  assign col_keep[0] = !s1_info.pad_left;
  assign col_keep[1] = 1'b1;
  assign col_keep[2] = !s1_info.pad_right;

  // Weighted sums for all kernels
  always_comb begin
    sum_mean  = '0;
    sum_sharp = '0;
    sum_lap   = '0;
    term      = '0;
    for (int i = 0; i < 3; i++) begin
      view[i][0] = wc1[i];
      view[i][1] = wc2[i];
      view[i][2] = newcol[i];
      for (int j = 0; j < 3; j++) begin
        term = (row_keep[i] && col_keep[j]) ? conv3_pkg::sum_t'(view[i][j]) : '0;
        sum_mean  = sum_mean + term;
        sum_sharp = sum_sharp + term * conv3_pkg::sum_t'(conv3_pkg::SHARPEN_K[i][j]);
        sum_lap   = sum_lap + term * conv3_pkg::sum_t'(conv3_pkg::LAPLACE_K[i][j]);
      end
    end
  end

  // Kernel select
  always_comb begin
    unique case (kernel_mode)
      conv3_pkg::MODE_SHARPEN: begin
        sum_sel  = sum_sharp;
        mean_sel = 1'b0;
      end
      conv3_pkg::MODE_LAPLACE: begin
        sum_sel  = sum_lap;
        mean_sel = 1'b0;
      end
      default: begin
        sum_sel  = sum_mean;
        mean_sel = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_info.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum  <= sum_sel;
      s2_mean <= mean_sel;
      s2_info <= s1_info;
    end
  end

endmodule

`default_nettype wire

>>> src/conv3_scale.sv
// ---------------------------------------------------------------------------
// conv3_scale: fixed-point scaling of the weighted sum
// Mean: divide by nine by reciprocal multiply, rounded to nearest.
// Other kernels: shift in the fraction bits and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module conv3_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 s2_valid,
  input  conv3_pkg::sum_t      s2_sum,
  input  logic                 s2_mean,
  input  conv3_pkg::emit_t     s2_info,
  output logic                 res_valid,
  output conv3_pkg::out_word_t res
);

  typedef logic signed [conv3_pkg::MEAN_P_BITS+1:0] pwide_t;
  typedef logic [conv3_pkg::MEAN_P_BITS-1:0]        p_t;
  typedef logic [conv3_pkg::PROD_BITS-1:0]          prod_t;
  typedef logic signed [conv3_pkg::SWIDE_BITS-1:0]  swide_t;
  typedef logic signed [conv3_pkg::QUO_BITS:0]      quo_t;

  localparam swide_t OUT_MAX = swide_t'(2 ** (conv3_pkg::OUT_BITS - 1) - 1);
  localparam swide_t OUT_MIN = swide_t'(-(2 ** (conv3_pkg::OUT_BITS - 1)));

  pwide_t               pw;
  p_t                   p;
  prod_t                s3_prod;
  conv3_pkg::sum_t      s3_sum;
  logic                 s3_mean;
  conv3_pkg::emit_t     s3_info;
  logic                 s3_valid;
  logic [conv3_pkg::QUO_BITS-1:0] quo;
  conv3_pkg::result_t   mean_val;
  swide_t               sv;
  conv3_pkg::result_t   sat_val;

  // Biased dividend, nonnegative over the mean's range
  assign pw = (pwide_t'(s2_sum) <<< conv3_pkg::FRACTION_BITS)
            + pwide_t'(conv3_pkg::MEAN_P_OFFSET);
  assign p  = pw[conv3_pkg::MEAN_P_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prod <= prod_t'(p) * prod_t'(conv3_pkg::RECIP);
      s3_sum  <= s2_sum;
      s3_mean <= s2_mean;
      s3_info <= s2_info;
    end
  end

  // Mean result: quotient minus bias
  assign quo      = s3_prod[conv3_pkg::PROD_BITS-1:conv3_pkg::RECIP_SHIFT];
  assign mean_val = conv3_pkg::result_t'(quo_t'({1'b0, quo}))
                  - conv3_pkg::result_t'(conv3_pkg::MEAN_Q_OFFSET);

  // Integer kernels: scale and saturate
  assign sv = swide_t'(s3_sum) <<< conv3_pkg::FRACTION_BITS;

  always_comb begin
    if (sv > OUT_MAX) begin
      sat_val = conv3_pkg::result_t'(OUT_MAX);
    end else if (sv < OUT_MIN) begin
      sat_val = conv3_pkg::result_t'(OUT_MIN);
    end else begin
      sat_val = conv3_pkg::result_t'(sv);
    end
  end

  assign res_valid = s3_valid;
  assign res.value = s3_mean ? mean_val : sat_val;
  assign res.row   = s3_info.row;
  assign res.col   = s3_info.col;
  assign res.last  = s3_info.last;

endmodule

`default_nettype wire

>>> src/conv3x3_zero_pad_filter.sv
// ---------------------------------------------------------------------------
// conv3x3_zero_pad_filter: 3x3 image filter with zero padding
// Throughput: one pixel or flush word per cycle unless a full output queue stalls it.
// A result passes the s1, s2 and s3 registers and the output queue before it
// shows on out_valid; the word that produces it trails its pixel by one row plus one.
// The line buffers sit in one column-addressed RAM, read then written back.
// Reset clears position, window and pipeline control; the line buffer RAM
// is not cleared (stale entries are always masked by the border logic).
// ---------------------------------------------------------------------------
`default_nettype none

module conv3x3_zero_pad_filter #(
  parameter int MAX_WIDTH  = conv3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = conv3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [conv3_pkg::INDEX_BITS-1:0]     cfg_index,
  input  logic [conv3_pkg::CFG_BITS-1:0]       cfg_data,
  // pixel input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  conv3_pkg::pixel_t                    pixel_value,
  input  logic                                 flush,
  // filtered output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output conv3_pkg::result_t                   filtered_value,
  output conv3_pkg::pos_t                      out_row,
  output conv3_pkg::pos_t                      out_column,
  output logic                                 frame_last
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);

  typedef logic [WW-1:0] dimw_t;
  typedef logic [HW-1:0] dimh_t;

  localparam dimw_t RST_W = dimw_t'((conv3_pkg::RESET_WIDTH > MAX_WIDTH) ?
                                    MAX_WIDTH : conv3_pkg::RESET_WIDTH);
  localparam dimh_t RST_H = dimh_t'((conv3_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
                                    MAX_HEIGHT : conv3_pkg::RESET_HEIGHT);

  logic [conv3_pkg::MODE_BITS-1:0] kernel_mode;
  dimw_t                img_width;
  dimh_t                img_height;
  dimw_t                w_clamp;
  dimh_t                h_clamp;

  logic                 adv;
  logic                 rd_en;
  logic [CW-1:0]        rd_addr;
  logic                 s1_valid;
  logic [CW-1:0]        s1_addr;
  conv3_pkg::pixel_t    s1_pix;
  conv3_pkg::emit_t     s1_info;
  logic                 s2_valid;
  conv3_pkg::sum_t      s2_sum;
  logic                 s2_mean;
  conv3_pkg::emit_t     s2_info;
  logic                 res_valid;
  conv3_pkg::out_word_t res;

  logic [1:0]           q_count;
  conv3_pkg::out_word_t q0;
  conv3_pkg::out_word_t q1;
  logic                 push;
  logic                 pop;
  logic                 push_slot;

  // Dimension clamp: zero reads as one, above max saturates
  always_comb begin
    if (cfg_data == '0) begin
      w_clamp = dimw_t'(1);
      h_clamp = dimh_t'(1);
    end else begin
      w_clamp = (32'(cfg_data) > 32'(MAX_WIDTH))  ? dimw_t'(MAX_WIDTH)  : dimw_t'(cfg_data);
      h_clamp = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? dimh_t'(MAX_HEIGHT) : dimh_t'(cfg_data);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode <= conv3_pkg::MODE_MEAN;
      img_width   <= RST_W;
      img_height  <= RST_H;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        conv3_pkg::REG_KERNEL_MODE:  kernel_mode <= cfg_data[conv3_pkg::MODE_BITS-1:0];
        conv3_pkg::REG_IMAGE_WIDTH:  img_width   <= w_clamp;
        conv3_pkg::REG_IMAGE_HEIGHT: img_height  <= h_clamp;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the last stage is blocked by a full queue
  assign adv      = !(res_valid && (q_count == 2'd2));
  assign in_ready = adv;

  conv3_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .pixel_value (pixel_value),
    .flush       (flush),
    .img_width   (img_width),
    .img_height  (img_height),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .s1_valid    (s1_valid),
    .s1_addr     (s1_addr),
    .s1_pix      (s1_pix),
    .s1_info     (s1_info)
  );

  conv3_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .kernel_mode (kernel_mode),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .s1_valid    (s1_valid),
    .s1_addr     (s1_addr),
    .s1_pix      (s1_pix),
    .s1_info     (s1_info),
    .s2_valid    (s2_valid),
    .s2_sum      (s2_sum),
    .s2_mean     (s2_mean),
    .s2_info     (s2_info)
  );

  conv3_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s2_valid  (s2_valid),
    .s2_sum    (s2_sum),
    .s2_mean   (s2_mean),
    .s2_info   (s2_info),
    .res_valid (res_valid),
    .res       (res)
  );

  // Two-word output queue decouples the pipeline from out_ready
  assign push      = res_valid && adv;
  assign pop       = out_valid && out_ready;
  assign push_slot = q_count[0] && !pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Head takes the new word when it lands there, else the second slot on a pop
  always_ff @(posedge clk) begin
    if (push && !push_slot) begin
      q0 <= res;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && push_slot) begin
      q1 <= res;
    end
  end

  assign out_valid      = (q_count != 2'd0);
  assign filtered_value = q0.value;
  assign out_row        = q0.row;
  assign out_column     = q0.col;
  assign frame_last     = q0.last;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3)
    else $error("output queue count out of range");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      (out_row == conv3_pkg::pos_t'(img_height - dimh_t'(1))) &&
      (out_column == conv3_pkg::pos_t'(img_width - dimw_t'(1))))
    else $error("frame_last word not at the bottom-right pixel");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output word present right after reset");

endmodule

`default_nettype wire
